// ===== rtl/vsl_pkg.sv =====
`default_nettype none
package vsl_pkg;
	localparam int unsigned W = 32;
	localparam int unsigned LANES = 3;
	localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};

	typedef logic [W-1:0] word_t;

	// sideband that travels with the square root
	typedef struct packed {
		logic [LANES-1:0][W-1:0] m;
		logic [W-1:0]            tmag;
		logic [LANES-1:0]        rneg;
		logic                    zero;
	} vec_pay_t;

	// sideband that travels with the division
	typedef struct packed {
		logic [LANES-1:0] rneg;
		logic             zero;
	} div_side_t;
endpackage
`default_nettype wire

// ===== rtl/vector_set_length_3d.sv =====
// stages: a 32-stage square root and a 32-stage divider, one result bit per stage,
// plus eight stages around them, between input request and result
// throughput: one request per cycle; a stall on the output freezes the whole pipeline
// reset: asynchronous, clears the valid bits only; no state is kept between requests
`default_nettype none
module vector_set_length_3d
	import vsl_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// in_x, in_y, in_z, target_length
	input  wire logic [127:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// out_x, out_y, out_z
	output logic [95:0]       m_axis_tdata,
	// was_zero, saturated
	output logic [1:0]        m_axis_tuser
);
	logic adv;
	logic out_valid_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: magnitudes, signs, largest component
	logic [LANES-1:0][W-1:0] in_c;
	logic [W-1:0]            in_t;
	logic [LANES-1:0][W-1:0] mag_c;
	logic [LANES-1:0]        neg_c;
	logic [W-1:0]            big_c;
	logic [W-1:0]            tmag_c;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			in_c[i]  = s_axis_tdata[i*W +: W];
			neg_c[i] = in_c[i][W-1];
			mag_c[i] = neg_c[i] ? W'(-in_c[i]) : in_c[i];
		end
		in_t   = s_axis_tdata[LANES*W +: W];
		tmag_c = in_t[W-1] ? W'(-in_t) : in_t;
		big_c  = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
		big_c  = (mag_c[2] > big_c) ? mag_c[2] : big_c;
	end

	logic                    vld_s1;
	logic [LANES-1:0][W-1:0] m_s1;
	logic [W-1:0]            big_s1;
	vec_pay_t                pay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1        <= mag_c;
			big_s1      <= big_c;
			pay_s1.m    <= '0;
			pay_s1.tmag <= tmag_c;
			pay_s1.rneg <= neg_c ^ {LANES{in_t[W-1]}};
			pay_s1.zero <= (big_c == '0);
		end
	end

	// stage 2: shift that brings the largest magnitude to bit W-2 or above
	logic [4:0] sh_c;

	always_comb begin
		sh_c = '0;
		for (int i = 0; i < W-1; i++) begin
			if (big_s1[i]) sh_c = 5'(W - 2 - i);
		end
		if (big_s1[W-1]) sh_c = '0;
	end

	logic                    vld_s2;
	logic [LANES-1:0][W-1:0] m_s2;
	logic [4:0]              sh_s2;
	vec_pay_t                pay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2   <= m_s1;
			sh_s2  <= sh_c;
			pay_s2 <= pay_s1;
		end
	end

	// stage 3: normalized magnitudes
	logic     vld_s3;
	vec_pay_t pay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s3.tmag <= pay_s2.tmag;
			pay_s3.rneg <= pay_s2.rneg;
			pay_s3.zero <= pay_s2.zero;
			for (int i = 0; i < LANES; i++) begin
				pay_s3.m[i] <= m_s2[i] << sh_s2;
			end
		end
	end

	// stage 4: squares
	logic                      vld_s4;
	logic [LANES-1:0][2*W-1:0] sq_s4;
	vec_pay_t                  pay_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s4 <= pay_s3;
			for (int i = 0; i < LANES; i++) begin
				sq_s4[i] <= {{W{1'b0}}, pay_s3.m[i]} * {{W{1'b0}}, pay_s3.m[i]};
			end
		end
	end

	// stage 5: sum of squares, at most 3 * 2^62
	logic           vld_s5;
	logic [2*W-1:0] sum_s5;
	vec_pay_t       pay_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			pay_s5 <= pay_s4;
		end
	end

	logic          sq_valid;
	logic [W-1:0]  len;
	vec_pay_t      sq_pay;

	vsl_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s5),
		.rad       (sum_s5),
		.in_pay    (pay_s5),
		.out_valid (sq_valid),
		.root      (len),
		.out_pay   (sq_pay)
	);

	// stage 6: products with the target length
	logic                      vld_s6;
	logic [LANES-1:0][2*W-1:0] prod_s6;
	logic [W-1:0]              len_s6;
	div_side_t                 side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s6[i] <= {{W{1'b0}}, sq_pay.m[i]} * {{W{1'b0}}, sq_pay.tmag};
			end
			len_s6       <= len;
			side_s6.rneg <= sq_pay.rneg;
			side_s6.zero <= sq_pay.zero;
		end
	end

	// stage 7: rounding term, half the length
	logic                      vld_s7;
	logic [LANES-1:0][2*W-2:0] num_s7;
	logic [W-1:0]              len_s7;
	div_side_t                 side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				num_s7[i] <= (2*W-1)'(prod_s6[i] + {{(W+1){1'b0}}, len_s6[W-1:1]});
			end
			len_s7  <= len_s6;
			side_s7 <= side_s6;
		end
	end

	logic                    dv_valid;
	logic [LANES-1:0][W-1:0] quo;
	div_side_t               dv_side;

	vsl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s7),
		.num       (num_s7),
		.den       (len_s7),
		.in_side   (side_s7),
		.out_valid (dv_valid),
		.quo       (quo),
		.out_side  (dv_side)
	);

	// output register: sign, saturation, zero vector
	logic [LANES-1:0][W-1:0] res_c;
	logic                    sat_c;
	logic [LANES-1:0][W-1:0] res_q;
	logic                    zero_q;
	logic                    sat_q;

	always_comb begin
		sat_c = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if (dv_side.zero || quo[i] == '0) begin
				res_c[i] = '0;
			end else if (dv_side.rneg[i]) begin
				res_c[i] = W'(-quo[i]);
			end else if (quo[i][W-1]) begin
				res_c[i] = POS_MAX;
				sat_c    = 1'b1;
			end else begin
				res_c[i] = quo[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q  <= res_c;
			zero_q <= dv_side.zero;
			sat_q  <= sat_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;
	assign m_axis_tuser  = {sat_q, zero_q};

`ifndef SYNTH
	a_zero_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("zero vector flagged as saturated");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("zero vector result is not zero");

	a_sat_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata[31:0] == POS_MAX
			|| m_axis_tdata[63:32] == POS_MAX || m_axis_tdata[95:64] == POS_MAX))
		else $error("saturation flag without clipped component");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> out_valid_q && $stable(res_q))
		else $error("result changed during stall");
`endif
endmodule
`default_nettype wire

// ===== rtl/vsl_isqrt.sv =====
`default_nettype none
module vsl_isqrt
	import vsl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       in_valid,
	input  wire logic [2*W-1:0] rad,
	input  wire vec_pay_t   in_pay,
	output logic            out_valid,
	output logic [W-1:0]    root,
	output vec_pay_t        out_pay
);
	localparam int unsigned N = W;
	localparam int unsigned RW = W + 2;

	logic           vld_s [0:N];
	logic [2*W-1:0] rad_s [0:N];
	logic [RW-1:0]  rem_s [0:N];
	logic [W-1:0]   root_s [0:N];
	vec_pay_t       pay_s [0:N];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign pay_s[0]  = in_pay;

	// one result bit per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW+1:0] trial;
		logic [RW+1:0] test;
		logic          take;

		always_comb begin
			trial = {rem_s[k], rad_s[k][2*W-1 -: 2]};
			test  = {{(RW-W){1'b0}}, root_s[k], 2'b01};
			take  = (trial >= test);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][2*W-3:0], 2'b00};
				rem_s[k+1]  <= take ? RW'(trial - test) : RW'(trial);
				root_s[k+1] <= {root_s[k][W-2:0], take};
				pay_s[k+1]  <= pay_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign root      = root_s[N];
	assign out_pay   = pay_s[N];
endmodule
`default_nettype wire

// ===== rtl/vsl_div.sv =====
`default_nettype none
module vsl_div
	import vsl_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [LANES-1:0][2*W-2:0]   num,
	input  wire logic [W-1:0]                den,
	input  wire div_side_t                   in_side,
	output logic                             out_valid,
	output logic [LANES-1:0][W-1:0]          quo,
	output div_side_t                        out_side
);
	localparam int unsigned N = W;

	logic                    vld_s  [0:N];
	logic [W-1:0]            den_s  [0:N];
	div_side_t               side_s [0:N];
	logic [LANES-1:0][W-1:0] rem_s  [0:N];
	logic [LANES-1:0][W-1:0] low_s  [0:N];
	logic [LANES-1:0][W-1:0] q_s    [0:N];

	assign vld_s[0]  = in_valid;
	assign den_s[0]  = den;
	assign side_s[0] = in_side;

	// quotient fits W bits, so the upper part of the numerator is below den
	for (genvar l = 0; l < LANES; l++) begin : g_init
		assign rem_s[0][l] = {1'b0, num[l][2*W-2:W]};
		assign low_s[0][l] = num[l][W-1:0];
		assign q_s[0][l]   = '0;
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [W:0] trial;
			logic       take;

			always_comb begin
				trial = {rem_s[k][l], low_s[k][l][W-1]};
				take  = (trial >= {1'b0, den_s[k]});
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l] <= take ? W'(trial - {1'b0, den_s[k]}) : W'(trial);
					low_s[k+1][l] <= {low_s[k][l][W-2:0], 1'b0};
					q_s[k+1][l]   <= {q_s[k][l][W-2:0], take};
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign quo       = q_s[N];
	assign out_side  = side_s[N];
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
	import vsl_pkg::*;

	typedef struct packed {
		word_t tlen;
		word_t z;
		word_t y;
		word_t x;
	} vec_req_t;

	typedef struct {
		word_t x;
		word_t y;
		word_t z;
		logic  was_zero;
		logic  sat;
	} scaled_t;

	localparam int LATENCY = 72;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [95:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	vector_set_length_3d dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	vec_req_t pending_reqs[$];
	scaled_t  expected_vecs[$];
	int       errors = 0;
	int       n_sent = 0;
	int       n_checked = 0;
	int       n_zero = 0;
	int       n_sat = 0;
	longint   cycles = 0;
	int       send_gap = 0;
	int       recv_gap = 0;
	int       hold_off = 0;
	bit       hold_armed = 1'b0;
	bit       hold_done = 1'b0;
	bit       in_taken = 1'b0;

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// the most negative word negates to itself, which reads as 2^31 unsigned
	function automatic logic [63:0] abs_word(word_t w);
		return w[W-1] ? {32'd0, -w} : {32'd0, w};
	endfunction

	function automatic scaled_t rescale(vec_req_t r);
		scaled_t     o;
		word_t       c[3];
		word_t       res[3];
		logic [63:0] m[3];
		logic [63:0] tmag;
		logic [63:0] big;
		logic [63:0] sumsq;
		logic [63:0] len;
		logic [63:0] q;
		int          s;
		c[0] = r.x;
		c[1] = r.y;
		c[2] = r.z;
		tmag = abs_word(r.tlen);
		big = 0;
		sumsq = 0;
		o.sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			m[i] = abs_word(c[i]);
			if (m[i] > big)
				big = m[i];
		end
		if (big == 0) begin
			o.x = r.x;
			o.y = r.y;
			o.z = r.z;
			o.was_zero = 1'b1;
			return o;
		end
		s = 0;
		while (big < (64'd1 << 30)) begin
			big <<= 1;
			s++;
		end
		for (int i = 0; i < 3; i++) begin
			m[i] <<= s;
			sumsq += m[i] * m[i];
		end
		len = int_sqrt(sumsq);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * tmag + (len >> 1)) / len;
			if (q == 0)
				res[i] = '0;
			else if (c[i][W-1] != r.tlen[W-1])
				res[i] = -q[31:0];
			else if (q > 64'h7FFF_FFFF) begin
				res[i] = POS_MAX;
				o.sat = 1'b1;
			end else
				res[i] = q[31:0];
		end
		o.x = res[0];
		o.y = res[1];
		o.z = res[2];
		o.was_zero = 1'b0;
		return o;
	endfunction

	function automatic word_t pick_component();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return $urandom_range(0, 15) - 8;
			4: return $urandom_range(0, 131071) - 65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	task automatic add_req(word_t x, word_t y, word_t z, word_t t);
		vec_req_t r;
		r.x = x;
		r.y = y;
		r.z = z;
		r.tlen = t;
		pending_reqs.push_back(r);
	endtask

	// driver: offers requests, changes at falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_taken) begin
				// hold current request
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				s_axis_tdata <= pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				if (n_sent > 400)
					send_gap <= pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver backpressure, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_armed && !hold_done) begin
				hold_off <= 300;
				hold_done <= 1'b1;
				m_axis_tready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (n_checked > 150 && $urandom_range(0, 3) == 0)
					recv_gap <= pick_gap();
			end
		end
	end

	// input side: predict on accepted request
	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			expected_vecs.push_back(rescale(vec_req_t'(s_axis_tdata)));
			n_sent <= n_sent + 1;
			if (n_sent == 200)
				hold_armed <= 1'b1;
		end
	end

	// output side: compare with oldest expectation
	always @(posedge clk) begin
		scaled_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_vecs.size() == 0) begin
				$error("unexpected result %h", m_axis_tdata);
				errors++;
			end else begin
				e = expected_vecs.pop_front();
				if (m_axis_tdata[31:0] !== e.x) begin
					$error("out_x expected %h got %h", e.x, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[63:32] !== e.y) begin
					$error("out_y expected %h got %h", e.y, m_axis_tdata[63:32]);
					errors++;
				end
				if (m_axis_tdata[95:64] !== e.z) begin
					$error("out_z expected %h got %h", e.z, m_axis_tdata[95:64]);
					errors++;
				end
				if (m_axis_tuser[0] !== e.was_zero) begin
					$error("was_zero expected %b got %b", e.was_zero, m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tuser[1] !== e.sat) begin
					$error("saturated expected %b got %b", e.sat, m_axis_tuser[1]);
					errors++;
				end
				n_zero += e.was_zero;
				n_sat += e.sat;
			end
			n_checked++;
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		word_t min_w;
		word_t max_w;
		word_t one_w;
		min_w = 32'h8000_0000;
		max_w = 32'h7FFF_FFFF;
		one_w = 32'h0001_0000;
		// zero vector, with various targets
		add_req('0, '0, '0, one_w);
		add_req('0, '0, '0, min_w);
		// plain normalization along each axis
		add_req(one_w, '0, '0, one_w);
		add_req('0, -one_w, '0, one_w);
		add_req('0, '0, 32'd3, one_w);
		// extremes of the components
		add_req(min_w, min_w, min_w, one_w);
		add_req(max_w, max_w, max_w, max_w);
		add_req(min_w, max_w, 32'd1, max_w);
		add_req(32'd1, 32'd1, 32'd1, one_w);
		add_req(32'hFFFF_FFFF, '0, '0, max_w);
		// negative target flips the vector
		add_req(one_w, 32'd2 << 16, 32'd3 << 16, -one_w);
		// positive overflow: negative component with most negative target
		add_req(min_w, '0, '0, min_w);
		add_req(32'hFFFF_FFFF, '0, '0, min_w);
		add_req(-one_w, 32'd5, '0, min_w);
		add_req(32'd3 << 16, 32'd4 << 16, '0, 32'd5 << 16);
		add_req(one_w, one_w, one_w, '0);
		add_req(max_w, 32'd1, min_w, 32'd7);
		for (int i = 0; i < 640; i++)
			add_req(pick_component(), pick_component(), pick_component(),
				($urandom_range(0, 3) == 0) ? one_w : pick_component());
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && !s_axis_tvalid);
		wait (expected_vecs.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("covered %0d requests: %0d zero vectors, %0d saturated results",
			n_sent, n_zero, n_sat);
		$display("directed extremes, random vectors and a long output stall");
		if (errors == 0 && expected_vecs.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
